// File: design/gps_pkg.sv
package gps_pkg;

  localparam int FracBits = 16;
  localparam int TimeW = 32;
  localparam int PeriodW = 24;
  localparam int TimingW = 2 * FracBits + 1;
  localparam int PhaseW = FracBits + 2;
  localparam int CfgIndexW = 3;
  localparam int FrontStages = TimeW + FracBits;
  localparam int BackStages = FracBits;

  localparam logic [PhaseW-1:0] PhaseOne = {2'b01, {FracBits{1'b0}}};

  localparam logic [PeriodW-1:0] PeriodReset = 24'd500000;
  localparam logic [TimingW-1:0] TimingResetEven = 33'd32768;
  localparam logic [TimingW-1:0] TimingResetOdd = 33'd4295000064;

  localparam logic [CfgIndexW-1:0] CfgPeriod = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgLegBase = 3'd1;

  typedef enum logic [1:0] {
    ModeZero,
    ModeFull,
    ModeSwing,
    ModeStance
  } mode_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: design/gps_front.sv
module gps_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gps_pkg::TimeW-1:0]            time_us_i,
  input  logic [gps_pkg::PeriodW-1:0]          period_i,
  input  logic                                 push_ok_i,
  output logic                                 push_o,
  output logic [gps_pkg::FracBits-1:0]         frac_o
);

  localparam int N = gps_pkg::FrontStages;
  localparam int PW = gps_pkg::PeriodW;
  localparam int TW = gps_pkg::TimeW;

  logic [N-1:0]  vld_q;
  logic [PW-1:0] rem_q [N];
  logic [PW-1:0] rem_d [N];
  logic [TW-1:0] sh_q [N];
  logic [TW-1:0] sh_d [N];
  logic          adv;

  assign adv = !vld_q[N-1] || push_ok_i;
  assign in_ready_o = adv;
  assign push_o = vld_q[N-1] && push_ok_i;
  assign frac_o = (period_i == '0) ? '0 : sh_q[N-1][gps_pkg::FracBits-1:0];

  always_comb begin
    logic [PW:0]   tmp;
    logic [PW-1:0] rin;
    logic [TW-1:0] sin;
    logic          fb;
    logic          ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rin = '0;
        sin = time_us_i;
      end else begin
        rin = rem_q[k-1];
        sin = sh_q[k-1];
      end
      fb = (k < TW) ? sin[TW-1] : 1'b0;
      tmp = {rin, fb};
      ge = tmp >= {1'b0, period_i};
      rem_d[k] = ge ? PW'(tmp - {1'b0, period_i}) : tmp[PW-1:0];
      sh_d[k] = {sin[TW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        sh_q[k] <= sh_d[k];
      end
    end
  end

endmodule

// File: design/gps_fifo.sv
module gps_fifo #(
  parameter int Width = 16,
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [Width-1:0]    data_i,
  input  logic                pop_i,
  output logic [Width-1:0]    data_o,
  output gps_pkg::fifo_stat_t stat_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q;
  logic [AW-1:0]    rd_q;
  logic [CW-1:0]    cnt_q;

  assign data_o = mem_q[rd_q];
  assign stat_o.full = cnt_q == CW'(Depth);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: design/gps_back.sv
module gps_back #(
  parameter int Legs = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gps_pkg::fifo_stat_t            stat_i,
  input  logic [gps_pkg::FracBits-1:0]   frac_i,
  output logic                           pop_o,
  input  logic [gps_pkg::TimingW-1:0]    timing_i [Legs],
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gps_pkg::PhaseW-1:0]     phase_o [Legs]
);

  localparam int M = gps_pkg::BackStages;
  localparam int FB = gps_pkg::FracBits;

  logic [M:0]          vld_q;
  gps_pkg::mode_e      mode_q [Legs][M+1];
  gps_pkg::mode_e      mode_d [Legs][M+1];
  logic [FB-1:0]       rem_q [Legs][M+1];
  logic [FB-1:0]       rem_d [Legs][M+1];
  logic [FB-1:0]       den_q [Legs][M+1];
  logic [FB-1:0]       den_d [Legs][M+1];
  logic [FB-1:0]       quo_q [Legs][M+1];
  logic [FB-1:0]       quo_d [Legs][M+1];
  logic                adv;

  assign adv = !vld_q[M] || out_ready_i;
  assign pop_o = !stat_i.empty && adv;
  assign out_valid_o = vld_q[M];

  always_comb begin
    logic [FB:0]   s;
    logic [FB-1:0] p;
    logic [FB-1:0] d;
    logic [FB:0]   tmp;
    logic          ge;
    for (int l = 0; l < Legs; l++) begin
      s = timing_i[l][FB:0];
      p = timing_i[l][2*FB:FB+1];
      d = frac_i - p;
      quo_d[l][0] = '0;
      if (s == '0) begin
        mode_d[l][0] = gps_pkg::ModeZero;
        rem_d[l][0] = '0;
        den_d[l][0] = '0;
      end else if (s[FB]) begin
        mode_d[l][0] = gps_pkg::ModeFull;
        rem_d[l][0] = '0;
        den_d[l][0] = '0;
      end else if (d < s[FB-1:0]) begin
        mode_d[l][0] = gps_pkg::ModeSwing;
        rem_d[l][0] = d;
        den_d[l][0] = s[FB-1:0];
      end else begin
        mode_d[l][0] = gps_pkg::ModeStance;
        rem_d[l][0] = d - s[FB-1:0];
        den_d[l][0] = FB'({1'b1, {FB{1'b0}}} - s);
      end
      for (int j = 1; j <= M; j++) begin
        tmp = {rem_q[l][j-1], 1'b0};
        ge = tmp >= {1'b0, den_q[l][j-1]};
        rem_d[l][j] = ge ? FB'(tmp - {1'b0, den_q[l][j-1]}) : tmp[FB-1:0];
        quo_d[l][j] = {quo_q[l][j-1][FB-2:0], ge};
        den_d[l][j] = den_q[l][j-1];
        mode_d[l][j] = mode_q[l][j-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Legs; l++) begin
      case (mode_q[l][M])
        gps_pkg::ModeZero:   phase_o[l] = '0;
        gps_pkg::ModeFull:   phase_o[l] = gps_pkg::PhaseOne + 1'b1;
        gps_pkg::ModeSwing:  phase_o[l] = {2'b00, quo_q[l][M]};
        gps_pkg::ModeStance: phase_o[l] = gps_pkg::PhaseOne + {2'b00, quo_q[l][M]};
        default:             phase_o[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[M-1:0], !stat_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < Legs; l++) begin
        for (int j = 0; j <= M; j++) begin
          mode_q[l][j] <= mode_d[l][j];
          rem_q[l][j] <= rem_d[l][j];
          den_q[l][j] <= den_d[l][j];
          quo_q[l][j] <= quo_d[l][j];
        end
      end
    end
  end

endmodule

// File: design/gait_phase_scheduler_core.sv
// Items pass the fraction divider, the queue, then the per-leg phase dividers.
// Throughput: one item per cycle while nothing stalls; the 48-stage modulo and
// fraction divider and 16-stage per-leg phase dividers take a new item each cycle.
// A four-entry queue parts the two pipelines so that each stalls on its own.
// Reset is asynchronous and active low; it empties the pipelines and the queue and
// loads the trot timing and a period of 500000 microseconds.
module gait_phase_scheduler_core #(
  parameter int LEGS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gps_pkg::TimeW-1:0]         time_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gps_pkg::PhaseW-1:0]        leg0_phase_o,
  output logic [gps_pkg::PhaseW-1:0]        leg1_phase_o,
  output logic [gps_pkg::PhaseW-1:0]        leg2_phase_o,
  output logic [gps_pkg::PhaseW-1:0]        leg3_phase_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gps_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [gps_pkg::TimingW-1:0]       cfg_data_i
);

  logic [gps_pkg::PeriodW-1:0]  period_q;
  logic [gps_pkg::TimingW-1:0]  timing_q [LEGS];
  logic [gps_pkg::PhaseW-1:0]   phase_b [LEGS];
  logic [gps_pkg::PhaseW-1:0]   phase_all [4];
  logic [gps_pkg::FracBits-1:0] frac_w;
  logic [gps_pkg::FracBits-1:0] frac_q;
  logic                         push_w;
  logic                         pop_w;
  gps_pkg::fifo_stat_t          stat_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= gps_pkg::PeriodReset;
    end else if (cfg_valid_i && cfg_index_i == gps_pkg::CfgPeriod) begin
      period_q <= cfg_data_i[gps_pkg::PeriodW-1:0];
    end
  end

  for (genvar i = 0; i < LEGS; i++) begin : g_timing
    localparam logic [gps_pkg::TimingW-1:0] Rst =
        (i % 2 == 0) ? gps_pkg::TimingResetEven : gps_pkg::TimingResetOdd;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        timing_q[i] <= Rst;
      end else if (cfg_valid_i &&
                   cfg_index_i == gps_pkg::CfgIndexW'(gps_pkg::CfgLegBase + i)) begin
        timing_q[i] <= cfg_data_i;
      end
    end
  end

  gps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .time_us_i  (time_us_i),
    .period_i   (period_q),
    .push_ok_i  (!stat_w.full),
    .push_o     (push_w),
    .frac_o     (frac_w)
  );

  gps_fifo #(
    .Width (gps_pkg::FracBits),
    .Depth (4)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_w),
    .data_i (frac_w),
    .pop_i  (pop_w),
    .data_o (frac_q),
    .stat_o (stat_w)
  );

  gps_back #(
    .Legs (LEGS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat_w),
    .frac_i      (frac_q),
    .pop_o       (pop_w),
    .timing_i    (timing_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .phase_o     (phase_b)
  );

  for (genvar i = 0; i < 4; i++) begin : g_out
    if (i < LEGS) begin : g_used
      assign phase_all[i] = phase_b[i];
    end else begin : g_unused
      assign phase_all[i] = '0;
    end
  end

  assign leg0_phase_o = phase_all[0];
  assign leg1_phase_o = phase_all[1];
  assign leg2_phase_o = phase_all[2];
  assign leg3_phase_o = phase_all[3];

endmodule

// File: design/gps_checker.sv
module gps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       cfg_ready_o,
  input logic [gps_pkg::PhaseW-1:0] leg0_phase_o,
  input logic [gps_pkg::PhaseW-1:0] leg1_phase_o,
  input logic [gps_pkg::PhaseW-1:0] leg2_phase_o,
  input logic [gps_pkg::PhaseW-1:0] leg3_phase_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result item withdrawn before it was taken.");

  a_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("Result valid fell without a handshake.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !leg0_phase_o[gps_pkg::PhaseW-1] && !leg1_phase_o[gps_pkg::PhaseW-1] &&
                    !leg2_phase_o[gps_pkg::PhaseW-1] && !leg3_phase_o[gps_pkg::PhaseW-1])
    else $error("Leg phase reached two.");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("Configuration port refused a write.");

endmodule

bind gait_phase_scheduler_core gps_checker u_chk (.*);
